>>> src/sspsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sspsc_pkg
// Shared types, constants and the pulse compare table for the servo
// position settle controller.
// ----------------------------------------------------------------------------
package sspsc_pkg;

   localparam int MODE_WIDTH    = 2;
   localparam int POS_WIDTH     = 4;
   localparam int TICKS_WIDTH   = 12;
   localparam int COUNT_WIDTH   = 16;
   localparam int COMPARE_WIDTH = 13;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   // operation codes
   localparam logic [MODE_WIDTH-1:0] MODE_SET   = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_TICK  = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_POLL  = 2'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_RESET = 2'd3;

   // register index
   localparam logic [0:0] REG_TICKS_PER_STEP = 1'b0;

   localparam logic [POS_WIDTH-1:0]   POS_COUNT   = 4'd13;
   localparam logic [POS_WIDTH-1:0]   HOME_POS    = 4'd6;
   localparam logic [TICKS_WIDTH-1:0] TICKS_RESET = 12'd100;
   localparam logic [COUNT_WIDTH-1:0] SETTLE_RESET =
      COUNT_WIDTH'(int'(HOME_POS) * int'(TICKS_RESET));

   typedef struct packed {
      logic [MODE_WIDTH-1:0] mode;
      logic [POS_WIDTH-1:0]  target_position;
   } req_type;

   typedef struct packed {
      logic                     accepted;
      logic                     out_of_range;
      logic                     compare_write;
      logic [COMPARE_WIDTH-1:0] pulse_compare;
      logic [POS_WIDTH-1:0]     current_position;
      logic                     ready_res;
   } rsp_type;

   function automatic logic [COMPARE_WIDTH-1:0] compare_value(
      input logic [POS_WIDTH-1:0] pos
   );
      logic [COMPARE_WIDTH-1:0] val;
      unique case (pos)
         4'd0:    val = 13'd1000;
         4'd1:    val = 13'd1417;
         4'd2:    val = 13'd1833;
         4'd3:    val = 13'd2250;
         4'd4:    val = 13'd2667;
         4'd5:    val = 13'd3083;
         4'd6:    val = 13'd3500;
         4'd7:    val = 13'd3916;
         4'd8:    val = 13'd4333;
         4'd9:    val = 13'd4750;
         4'd10:   val = 13'd5167;
         4'd11:   val = 13'd5583;
         4'd12:   val = 13'd6000;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

>>> src/sspsc_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sspsc_req_if
// Request channel: valid/ready handshake with operation and target index.
// ----------------------------------------------------------------------------
interface sspsc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [3:0] target_position;

   modport source (output valid, output mode, output target_position, input ready);
   modport sink   (input valid, input mode, input target_position, output ready);
endinterface
`default_nettype wire

>>> src/sspsc_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sspsc_rsp_if
// Result channel: valid/ready handshake with status and pulse compare value.
// ----------------------------------------------------------------------------
interface sspsc_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic        out_of_range;
   logic        compare_write;
   logic [12:0] pulse_compare;
   logic [3:0]  current_position;
   logic        ready_res;

   modport source (output valid, output accepted, output out_of_range,
                   output compare_write, output pulse_compare,
                   output current_position, output ready_res, input ready);
   modport sink   (input valid, input accepted, input out_of_range,
                   input compare_write, input pulse_compare,
                   input current_position, input ready_res, output ready);
endinterface
`default_nettype wire

>>> src/sspsc_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sspsc_csr
// APB-style register block holding the ticks-per-step setting.
// ----------------------------------------------------------------------------
module sspsc_csr
   import sspsc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] prdata,
   output logic                           pready,
   output logic      [TICKS_WIDTH-1:0]    ticks_per_step
);

   logic [TICKS_WIDTH-1:0] ticks_ff;
   logic [TICKS_WIDTH-1:0] ticks_in;
   logic                   sel_ticks;

   // word index sits above the byte offset
   assign sel_ticks = (paddr[CSR_ADDR_WIDTH-1] == REG_TICKS_PER_STEP);

   always_comb begin
      ticks_in = ticks_ff;
      if (psel && penable && pwrite && sel_ticks) begin
         ticks_in = pwdata[TICKS_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= TICKS_RESET;
      end else begin
         ticks_ff <= ticks_in;
      end
   end

   assign pready         = 1'b1;
   assign prdata         = sel_ticks ? CSR_DATA_WIDTH'(ticks_ff) : '0;
   assign ticks_per_step = ticks_ff;

endmodule
`default_nettype wire

>>> src/sspsc_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sspsc_in_stage
// Input register for one request, released when the result stage can take it.
// ----------------------------------------------------------------------------
module sspsc_in_stage
   import sspsc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   input  wire logic    advance,
   output logic         item_valid,
   output req_type      item_data
);

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;
   req_type data_in;
   logic    take;

   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (take) begin
         valid_in = 1'b1;
         data_in  = req_data;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;

endmodule
`default_nettype wire

>>> src/sspsc_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sspsc_core
// Position, settle countdown and busy state, with the result register.
// ----------------------------------------------------------------------------
module sspsc_core
   import sspsc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [TICKS_WIDTH-1:0] ticks_per_step,
   input  wire logic                   item_valid,
   input  wire req_type                item_data,
   output logic                        advance,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_data
);

   logic [POS_WIDTH-1:0]   pos_ff,   pos_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   busy_ff,  busy_in;
   logic                   out_valid_ff, out_valid_in;
   rsp_type                out_ff,   out_in;

   logic [POS_WIDTH-1:0]   travel;
   logic [COUNT_WIDTH-1:0] move_count;
   logic [COUNT_WIDTH-1:0] home_count;
   logic                   acc;
   logic                   oor;
   logic                   wr;

   assign advance = item_valid && (!out_valid_ff || rsp_ready);

   assign travel = (item_data.target_position > pos_ff) ?
                   (item_data.target_position - pos_ff) :
                   (pos_ff - item_data.target_position);
   assign move_count = COUNT_WIDTH'(travel) * COUNT_WIDTH'(ticks_per_step);
   assign home_count = COUNT_WIDTH'(HOME_POS) * COUNT_WIDTH'(ticks_per_step);

   always_comb begin
      pos_in   = pos_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      acc      = 1'b0;
      oor      = 1'b0;
      wr       = 1'b0;
      unique case (item_data.mode)
         MODE_SET: begin
            // range check wins over the busy check
            if (item_data.target_position >= POS_COUNT) begin
               oor = 1'b1;
            end else if (!busy_ff) begin
               acc = 1'b1;
               if (item_data.target_position != pos_ff) begin
                  count_in = move_count;
                  pos_in   = item_data.target_position;
                  busy_in  = 1'b1;
                  wr       = 1'b1;
               end
            end
         end
         MODE_TICK: begin
            if (count_ff != '0) begin
               count_in = count_ff - 1'b1;
            end
         end
         MODE_POLL: begin
            if (busy_ff && count_ff == '0) begin
               busy_in = 1'b0;
            end
         end
         MODE_RESET: begin
            pos_in   = HOME_POS;
            count_in = home_count;
            busy_in  = 1'b1;
            wr       = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      out_in.accepted         = acc;
      out_in.out_of_range     = oor;
      out_in.compare_write    = wr;
      out_in.pulse_compare    = compare_value(pos_in);
      out_in.current_position = pos_in;
      out_in.ready_res        = !busy_in;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= HOME_POS;
         count_ff     <= SETTLE_RESET;
         busy_ff      <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            pos_ff   <= pos_in;
            count_ff <= count_in;
            busy_ff  <= busy_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
`default_nettype wire

>>> src/servo_step_position_settle_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// servo_step_position_settle_controller
// Hobby servo position controller: 13 positions, settle countdown, busy flag.
// ----------------------------------------------------------------------------
// a request is registered in the input stage, then its result in the result register
// throughput: one request per cycle while results are taken; state update and result share one stage
// a waiting result holds the input register; a new request is taken only when it empties
// reset: position 6, countdown 600, busy set, ticks per step 100, no result
module servo_step_position_settle_controller
   import sspsc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   sspsc_req_if.sink                      req_bus,
   sspsc_rsp_if.source                    rsp_bus,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                           csr_pready
);

   logic [TICKS_WIDTH-1:0] ticks_per_step;
   req_type                req_data;
   req_type                item_data;
   logic                   item_valid;
   logic                   advance;
   rsp_type                rsp_data;

   assign req_data.mode            = req_bus.mode;
   assign req_data.target_position = req_bus.target_position;

   sspsc_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (csr_psel),
      .penable        (csr_penable),
      .pwrite         (csr_pwrite),
      .paddr          (csr_paddr),
      .pwdata         (csr_pwdata),
      .prdata         (csr_prdata),
      .pready         (csr_pready),
      .ticks_per_step (ticks_per_step)
   );

   sspsc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_ready  (req_bus.ready),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item_data  (item_data)
   );

   sspsc_core u_core (
      .clock          (clock),
      .reset          (reset),
      .ticks_per_step (ticks_per_step),
      .item_valid     (item_valid),
      .item_data      (item_data),
      .advance        (advance),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_data       (rsp_data)
   );

   assign rsp_bus.accepted         = rsp_data.accepted;
   assign rsp_bus.out_of_range     = rsp_data.out_of_range;
   assign rsp_bus.compare_write    = rsp_data.compare_write;
   assign rsp_bus.pulse_compare    = rsp_data.pulse_compare;
   assign rsp_bus.current_position = rsp_data.current_position;
   assign rsp_bus.ready_res        = rsp_data.ready_res;

endmodule
`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the servo position settle controller against a cycle-free model of
// its position, settle countdown and busy flag. Directed requests cover the
// reset state, out-of-range and refused moves, the countdown floor and soft
// reset; random traffic runs under several ticks-per-step settings with
// random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module testbench;
   import sspsc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr   = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   sspsc_req_if req_bus ();
   sspsc_rsp_if rsp_bus ();

   servo_step_position_settle_controller dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // model state of the servo
   logic [TICKS_WIDTH-1:0] servo_ticks = TICKS_RESET;
   logic [POS_WIDTH-1:0]   servo_pos   = HOME_POS;
   logic [COUNT_WIDTH-1:0] servo_count = SETTLE_RESET;
   logic                   servo_busy  = 1'b1;

   logic [COMPARE_WIDTH-1:0] pulse_lut [13] = '{
      13'd1000, 13'd1417, 13'd1833, 13'd2250, 13'd2667, 13'd3083, 13'd3500,
      13'd3916, 13'd4333, 13'd4750, 13'd5167, 13'd5583, 13'd6000
   };

   rsp_type expected_rsp [$];
   rsp_type want_rsp;
   int      fault_count    = 0;
   bit      quiet_req      = 1'b0;
   bit      quiet_rsp      = 1'b0;
   int      rsp_stall_left = 0;

   initial begin
      req_bus.valid           = 1'b0;
      req_bus.mode            = MODE_SET;
      req_bus.target_position = '0;
      rsp_bus.ready           = 1'b0;
   end

   function automatic rsp_type predict_servo(input logic [MODE_WIDTH-1:0] mode,
                                             input logic [POS_WIDTH-1:0] target);
      rsp_type              r;
      logic [POS_WIDTH-1:0] travel;
      r = '0;
      case (mode)
         MODE_SET: begin
            if (target >= POS_COUNT) begin
               r.out_of_range = 1'b1;
            end else if (!servo_busy) begin
               r.accepted = 1'b1;
               if (target != servo_pos) begin
                  travel = (target > servo_pos) ? target - servo_pos : servo_pos - target;
                  servo_count = COUNT_WIDTH'(32'(travel) * 32'(servo_ticks));
                  servo_pos = target;
                  servo_busy = 1'b1;
                  r.compare_write = 1'b1;
               end
            end
         end
         MODE_TICK: begin
            if (servo_count != '0) servo_count = servo_count - 1'b1;
         end
         MODE_POLL: begin
            if (servo_busy && servo_count == '0) servo_busy = 1'b0;
         end
         MODE_RESET: begin
            servo_pos = HOME_POS;
            servo_count = COUNT_WIDTH'(32'(HOME_POS) * 32'(servo_ticks));
            servo_busy = 1'b1;
            r.compare_write = 1'b1;
         end
      endcase
      r.pulse_compare    = pulse_lut[servo_pos];
      r.current_position = servo_pos;
      r.ready_res        = !servo_busy;
      return r;
   endfunction

   // mostly no gap, some short ones, a few long ones
   function automatic int idle_length(input bit quiet);
      int pick;
      if (quiet) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 70) return 0;
      if (pick < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_request(input logic [MODE_WIDTH-1:0] mode,
                               input logic [POS_WIDTH-1:0] target);
      int gap;
      gap = idle_length(quiet_req);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.mode            <= mode;
      req_bus.target_position <= target;
      do @(posedge clock); while (!req_bus.ready);
      expected_rsp.push_back(predict_servo(mode, target));
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_ticks(input logic [TICKS_WIDTH-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_WIDTH'(4 * REG_TICKS_PER_STEP);
      csr_pwdata  <= CSR_DATA_WIDTH'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      servo_ticks = value;
      // read back
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_WIDTH'(value)) begin
         $display("%0t: ticks_per_step readback expected %0d actual %0d",
                  $time, value, csr_prdata);
         fault_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         fault_count++;
      end
   endtask

   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_bus.ready  <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else begin
         rsp_bus.ready  <= 1'b1;
         rsp_stall_left <= idle_length(quiet_rsp);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: result with no request pending", $time);
            fault_count++;
         end else begin
            want_rsp = expected_rsp.pop_front();
            check_field("accepted", 16'(want_rsp.accepted), 16'(rsp_bus.accepted));
            check_field("out_of_range", 16'(want_rsp.out_of_range),
                        16'(rsp_bus.out_of_range));
            check_field("compare_write", 16'(want_rsp.compare_write),
                        16'(rsp_bus.compare_write));
            check_field("pulse_compare", 16'(want_rsp.pulse_compare),
                        16'(rsp_bus.pulse_compare));
            check_field("current_position", 16'(want_rsp.current_position),
                        16'(rsp_bus.current_position));
            check_field("ready_res", 16'(want_rsp.ready_res), 16'(rsp_bus.ready_res));
         end
      end
   end

   // still settling from reset: moves refused, bad indexes flagged
   task automatic test_reset_state();
      send_request(MODE_POLL, 4'd0);
      send_request(MODE_SET, 4'd3);
      send_request(MODE_SET, 4'd13);
      send_request(MODE_SET, 4'd15);
      send_request(MODE_TICK, 4'd9);
   endtask

   task automatic test_soft_reset_settle();
      wait_for_results();
      write_ticks(12'd1);
      send_request(MODE_RESET, 4'd10);
      repeat (6) send_request(MODE_TICK, 4'd0);
      // countdown already at zero
      send_request(MODE_TICK, 4'd15);
      send_request(MODE_POLL, 4'd0);
      send_request(MODE_POLL, 4'd7);
   endtask

   task automatic test_set_position();
      send_request(MODE_SET, HOME_POS);
      send_request(MODE_SET, 4'd0);
      send_request(MODE_SET, 4'd12);
      repeat (6) send_request(MODE_TICK, 4'd5);
      send_request(MODE_POLL, 4'd0);
   endtask

   // full travel at the slowest rate, then soft reset out of it
   task automatic test_widest_travel();
      wait_for_results();
      write_ticks(12'd4095);
      send_request(MODE_SET, 4'd12);
      send_request(MODE_POLL, 4'd0);
      send_request(MODE_RESET, 4'd0);
   endtask

   task automatic test_random_traffic(input logic [TICKS_WIDTH-1:0] ticks,
                                      input int count, input bit quiet);
      int                    n;
      int                    pick;
      logic [MODE_WIDTH-1:0] mode;
      logic [POS_WIDTH-1:0]  target;
      wait_for_results();
      write_ticks(ticks);
      for (n = 0; n < count; n++) begin
         quiet_req = quiet || (n % 100 >= 80);
         quiet_rsp = quiet || (n % 100 >= 75 && n % 100 < 95);
         pick = $urandom_range(0, 99);
         if (pick < 28) mode = MODE_SET;
         else if (pick < 70) mode = MODE_TICK;
         else if (pick < 95) mode = MODE_POLL;
         else mode = MODE_RESET;
         if ($urandom_range(0, 99) < 15) target = POS_WIDTH'($urandom_range(13, 15));
         else target = POS_WIDTH'($urandom_range(0, 12));
         send_request(mode, target);
      end
      quiet_req = 1'b0;
      quiet_rsp = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_soft_reset_settle();
      test_set_position();
      test_widest_travel();
      test_random_traffic(12'd2, 150, 1'b0);
      test_random_traffic(12'd1, 120, 1'b1);
      test_random_traffic(12'd3, 150, 1'b0);
      test_random_traffic(TICKS_WIDTH'($urandom_range(4, 8)), 150, 1'b0);
      test_random_traffic(12'd4095, 40, 1'b0);
      test_random_traffic(TICKS_WIDTH'($urandom_range(1, 4095)), 40, 1'b0);
      test_random_traffic(12'd5, 150, 1'b0);
      wait_for_results();
      if (fault_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("testbench failed");
      $finish;
   end

endmodule
